@@ hdl/yuy2rgb_pkg.sv @@
`timescale 1ns / 1ps

package yuy2rgb_pkg;

    // Line store depth default, in pixel pairs
    localparam int MAX_PAIRS_DEF = 1024;

    // Configuration register
    localparam int            PPL_W      = 11;
    localparam logic [10:0]   PPL_RESET  = 11'd320;
    localparam int            APB_ADDR_W = 3;
    localparam int            APB_DATA_W = 32;
    localparam logic [0:0]    REG_PAIRS_PER_LINE = 1'b0;

    // Stream word widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;
    localparam int CHROMA_W = 16;

    // BT.601 studio-range coefficients, Q16
    localparam logic signed [18:0] K_Y  = 19'sd76310;
    localparam logic signed [18:0] K_RV = 19'sd104595;
    localparam logic signed [18:0] K_GU = 19'sd25677;
    localparam logic signed [18:0] K_GV = 19'sd53281;
    localparam logic signed [18:0] K_BU = 19'sd132199;

    // Product and sum widths (all sums stay well inside 2^28)
    localparam int PROD_W = 28;
    localparam int SUM_W  = 29;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic en_mul;
        logic en_clip;
    } t_lane_ctrl;

    // Q16 sum -> 0..255: negative clips to 0, overflow clips to 255
    function automatic logic [7:0] clip_q16(input logic signed [SUM_W-1:0] sum);
        logic [7:0] res;
        if (sum[SUM_W-1]) begin
            res = 8'd0;
        end else if (|sum[SUM_W-2:24]) begin
            res = 8'd255;
        end else begin
            res = sum[23:16];
        end
        return res;
    endfunction

endpackage

@@ hdl/yuy2rgb_ram.sv @@
`timescale 1ns / 1ps

module yuy2rgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/yuy2rgb_lane.sv @@
`timescale 1ns / 1ps

module yuy2rgb_lane (
    input  logic                    i_clk,
    input  yuy2rgb_pkg::t_lane_ctrl i_ctrl,
    input  logic [7:0]              i_luma,
    input  logic [7:0]              i_cb,
    input  logic [7:0]              i_cr,
    output yuy2rgb_pkg::t_rgb       o_rgb
);

    logic signed [9:0] w_ydiff;
    logic signed [8:0] w_cbd;
    logic signed [8:0] w_crd;

    logic signed [yuy2rgb_pkg::PROD_W-1:0] r_yy, r_rv, r_gu, r_gv, r_bu;
    logic signed [yuy2rgb_pkg::SUM_W-1:0]  w_sum_r, w_sum_g, w_sum_b;
    yuy2rgb_pkg::t_rgb                     r_rgb;

    // offset removal
    assign w_ydiff = $signed({2'b00, i_luma}) - 10'sd16;
    assign w_cbd   = $signed({1'b0, i_cb}) - 9'sd128;
    assign w_crd   = $signed({1'b0, i_cr}) - 9'sd128;

    // stage A: coefficient products
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_mul) begin
            r_yy <= yuy2rgb_pkg::PROD_W'(yuy2rgb_pkg::K_Y)  * yuy2rgb_pkg::PROD_W'(w_ydiff);
            r_rv <= yuy2rgb_pkg::PROD_W'(yuy2rgb_pkg::K_RV) * yuy2rgb_pkg::PROD_W'(w_crd);
            r_gu <= yuy2rgb_pkg::PROD_W'(yuy2rgb_pkg::K_GU) * yuy2rgb_pkg::PROD_W'(w_cbd);
            r_gv <= yuy2rgb_pkg::PROD_W'(yuy2rgb_pkg::K_GV) * yuy2rgb_pkg::PROD_W'(w_crd);
            r_bu <= yuy2rgb_pkg::PROD_W'(yuy2rgb_pkg::K_BU) * yuy2rgb_pkg::PROD_W'(w_cbd);
        end
    end

    // stage B: sums, shift and clip
    assign w_sum_r = yuy2rgb_pkg::SUM_W'(r_yy) + yuy2rgb_pkg::SUM_W'(r_rv);
    assign w_sum_g = yuy2rgb_pkg::SUM_W'(r_yy) - yuy2rgb_pkg::SUM_W'(r_gu)
                   - yuy2rgb_pkg::SUM_W'(r_gv);
    assign w_sum_b = yuy2rgb_pkg::SUM_W'(r_yy) + yuy2rgb_pkg::SUM_W'(r_bu);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_clip) begin
            r_rgb.red   <= yuy2rgb_pkg::clip_q16(w_sum_r);
            r_rgb.green <= yuy2rgb_pkg::clip_q16(w_sum_g);
            r_rgb.blue  <= yuy2rgb_pkg::clip_q16(w_sum_b);
        end
    end

    assign o_rgb = r_rgb;

endmodule

@@ hdl/yuy2_to_rgb32_converter_core.sv @@
`timescale 1ns / 1ps

// YUY2 to RGB32 pixel-pair converter, BT.601 studio range, 4:2:0 chroma.
// Input stream: one word per YUY2 pair (Y0 Cb Y1 Cr in s_axis_tdata), with
// s_axis_tuser marking the first word of a frame (clears column and line parity).
// Output stream: one word per pair, left then right pixel as R,G,B bytes in
// m_axis_tdata; m_axis_tlast marks the last pair of a line.
// Even lines use their own Cb/Cr and store it in a line RAM; odd lines reuse
// the stored chroma of the line above. The line length (pairs_per_line) is set
// over APB at address 0; the user must write it only while idle (not enforced).
// m_axis_tvalid rises after the accepted word has passed four register stages:
// line RAM read, product registers, clip registers, output register.
// Throughput is one word per cycle while m_axis_tready stays high, set by two
// parallel pixel lanes each fully pipelined.
// Every stage has its own valid bit, so input words keep flowing into empty
// stages while a finished word waits on m_axis_tready; with all four stages
// full and the output stalled, s_axis_tready drops.
// Synchronous reset empties the pipeline, holds s_axis_tready low and restores
// column 0, even line and pairs_per_line = 320; the line RAM is not cleared.
module yuy2_to_rgb32_converter_core #(
    parameter int MAX_PAIRS = yuy2rgb_pkg::MAX_PAIRS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  logic [yuy2rgb_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // [0] frame_start
    input  logic                                s_axis_tuser,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] red_left, [15:8] green_left, [23:16] blue_left,
    // [31:24] red_right, [39:32] green_right, [47:40] blue_right
    output logic [yuy2rgb_pkg::M_DATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [yuy2rgb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [yuy2rgb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [yuy2rgb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready
);

    localparam int COL_W  = $clog2(MAX_PAIRS);
    localparam int LEN_W  = $clog2(MAX_PAIRS + 1);
    localparam int CMP_W  = ((LEN_W > yuy2rgb_pkg::PPL_W) ? LEN_W : yuy2rgb_pkg::PPL_W) + 1;

    // ---------------- configuration ----------------
    logic [yuy2rgb_pkg::PPL_W-1:0] r_ppl;
    logic                          w_cfg_sel;
    logic                          w_cfg_wr;

    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[2] == yuy2rgb_pkg::REG_PAIRS_PER_LINE);
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_cfg_sel;
    assign prdata    = w_cfg_sel ? yuy2rgb_pkg::APB_DATA_W'(r_ppl) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppl <= yuy2rgb_pkg::PPL_RESET;
        end else if (w_cfg_wr) begin
            r_ppl <= pwdata[yuy2rgb_pkg::PPL_W-1:0];
        end
    end

    // ---------------- pipeline handshake ----------------
    logic r_v1, r_v2, r_v3, r_vout;
    logic w_ld_out, w_ld3, w_ld2, w_accept;

    assign w_ld_out      = r_v3 && (!r_vout || m_axis_tready);
    assign w_ld3         = r_v2 && (!r_v3 || w_ld_out);
    assign w_ld2         = r_v1 && (!r_v2 || w_ld3);
    assign s_axis_tready = i_rst_n && (!r_v1 || w_ld2);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            if (w_accept)      r_v1 <= 1'b1;
            else if (w_ld2)    r_v1 <= 1'b0;
            if (w_ld2)         r_v2 <= 1'b1;
            else if (w_ld3)    r_v2 <= 1'b0;
            if (w_ld3)         r_v3 <= 1'b1;
            else if (w_ld_out) r_v3 <= 1'b0;
            if (w_ld_out)           r_vout <= 1'b1;
            else if (m_axis_tready) r_vout <= 1'b0;
        end
    end

    // ---------------- column and line tracking ----------------
    logic [COL_W-1:0] r_col, n_col;
    logic             r_odd, n_odd;
    logic [COL_W-1:0] w_eff_col;
    logic             w_eff_odd;
    logic [CMP_W-1:0] w_ppl_ext, w_len;
    logic             w_last;

    assign w_eff_col = s_axis_tuser ? '0 : r_col;
    assign w_eff_odd = s_axis_tuser ? 1'b0 : r_odd;

    // clamp line length to 1..MAX_PAIRS
    assign w_ppl_ext = CMP_W'(r_ppl);
    always_comb begin
        if (r_ppl == '0) begin
            w_len = CMP_W'(1);
        end else if (w_ppl_ext > CMP_W'(MAX_PAIRS)) begin
            w_len = CMP_W'(MAX_PAIRS);
        end else begin
            w_len = w_ppl_ext;
        end
    end

    assign w_last = (CMP_W'(w_eff_col) + CMP_W'(1)) >= w_len;

    always_comb begin
        if (w_last) begin
            n_col = '0;
            n_odd = !w_eff_odd;
        end else begin
            n_col = w_eff_col + COL_W'(1);
            n_odd = w_eff_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_odd <= 1'b0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_odd <= n_odd;
        end
    end

    // ---------------- line store ----------------
    logic [yuy2rgb_pkg::CHROMA_W-1:0] w_rd_data;

    yuy2rgb_ram #(
        .WIDTH (yuy2rgb_pkg::CHROMA_W),
        .DEPTH (MAX_PAIRS)
    ) u_chroma_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && !w_eff_odd),
        .i_wr_addr (w_eff_col),
        .i_wr_data ({s_axis_tdata[15:8], s_axis_tdata[31:24]}),
        .i_rd_en   (w_accept && w_eff_odd),
        .i_rd_addr (w_eff_col),
        .o_rd_data (w_rd_data)
    );

    // ---------------- stage 1 payload ----------------
    logic [7:0] r_y0_1, r_y1_1, r_cb_1, r_cr_1;
    logic       r_odd_1, r_last_1, r_last_2, r_last_3;
    logic [7:0] w_cb, w_cr;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_y0_1   <= s_axis_tdata[7:0];
            r_cb_1   <= s_axis_tdata[15:8];
            r_y1_1   <= s_axis_tdata[23:16];
            r_cr_1   <= s_axis_tdata[31:24];
            r_odd_1  <= w_eff_odd;
            r_last_1 <= w_last;
        end
        if (w_ld2)    r_last_2 <= r_last_1;
        if (w_ld3)    r_last_3 <= r_last_2;
    end

    // odd lines take the chroma of the line above
    assign w_cb = r_odd_1 ? w_rd_data[15:8] : r_cb_1;
    assign w_cr = r_odd_1 ? w_rd_data[7:0]  : r_cr_1;

    // ---------------- pixel lanes ----------------
    yuy2rgb_pkg::t_lane_ctrl w_lane_ctrl;
    yuy2rgb_pkg::t_rgb       w_rgb_left, w_rgb_right;

    assign w_lane_ctrl.en_mul  = w_ld2;
    assign w_lane_ctrl.en_clip = w_ld3;

    yuy2rgb_lane u_lane_left (
        .i_clk  (i_clk),
        .i_ctrl (w_lane_ctrl),
        .i_luma (r_y0_1),
        .i_cb   (w_cb),
        .i_cr   (w_cr),
        .o_rgb  (w_rgb_left)
    );

    yuy2rgb_lane u_lane_right (
        .i_clk  (i_clk),
        .i_ctrl (w_lane_ctrl),
        .i_luma (r_y1_1),
        .i_cb   (w_cb),
        .i_cr   (w_cr),
        .o_rgb  (w_rgb_right)
    );

    // ---------------- merge into output word ----------------
    logic [yuy2rgb_pkg::M_DATA_W-1:0] r_tdata;
    logic                             r_tlast;

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_tdata <= {w_rgb_right.blue, w_rgb_right.green, w_rgb_right.red,
                        w_rgb_left.blue,  w_rgb_left.green,  w_rgb_left.red};
            r_tlast <= r_last_3;
        end
    end

    assign m_axis_tvalid = r_vout;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;

    // ---------------- assertions ----------------
    a_line_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_col == '0))
        else $error("column did not wrap at line end");

    a_parity_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_odd != $past(w_eff_odd)))
        else $error("line parity did not toggle at line end");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vout && !m_axis_tready && r_v3 && r_v2 && r_v1) |-> !s_axis_tready)
        else $error("input accepted with full stalled pipeline");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (CMP_W'(r_col) < w_len || r_col == '0 || $past(w_cfg_wr)
                      || CMP_W'(r_col) < CMP_W'(MAX_PAIRS)))
        else $error("column beyond line store");

endmodule
